FILE: rtl/mdv_pkg.sv
// mdv_pkg: shared types and constants for the modulated delay vibrato core
// register indexes, reset values, sample limits and sine polynomial coefficients
// no dependencies
package mdv_pkg;

  localparam int SAMPLE_W = 24;
  localparam int CFG_W    = 23;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC  = 3'd0,
    REG_BASE_DELAY = 3'd1,
    REG_DEPTH      = 3'd2,
    REG_MIX        = 3'd3,
    REG_CHANNELS   = 3'd4
  } cfg_reg_t;

  localparam logic [22:0] PHASE_INC_RST  = 23'd447392;
  localparam logic [17:0] BASE_DELAY_RST = 18'd73728;
  localparam logic [17:0] DEPTH_RST      = 18'd24576;
  localparam logic [16:0] MIX_RST        = 17'd65536;
  localparam logic [1:0]  CHANNELS_RST   = 2'd2;

  localparam logic [16:0] MIX_ONE = 17'd65536;

  localparam logic signed [25:0] SAT_MAX = 26'sd8388607;
  localparam logic signed [25:0] SAT_MIN = -26'sd8388608;

  // q28 coefficients of the odd degree 9 sine polynomial
  localparam logic [63:0] SIN_C1 = 64'd421657428;
  localparam logic [63:0] SIN_C3 = 64'd173399667;
  localparam logic [63:0] SIN_C5 = 64'd21392326;
  localparam logic [63:0] SIN_C7 = 64'd1256749;
  localparam logic [63:0] SIN_C9 = 64'd43068;

endpackage

FILE: rtl/modulated_delay_vibrato_core.sv
// Timing: an item is taken only in S_IDLE and passes S_RDA, S_RDB, S_IMUL, S_IADD, S_MMUL
// and S_OUT, which waits for the output to be free, before the next item is taken. The first
// channel of a frame first passes S_PHASE to S_MOD: LFO table lookup, depth multiply and the
// shift-subtract reduction of the delay modulo the line length (one step per cycle).
// After rst the delay memory is cleared at one entry per cycle, with s_axis_tready low;
// configuration writes are taken throughout.
module modulated_delay_vibrato_core #(
  parameter int DELAY_LEN       = 1024,
  parameter int CHAN_SLOTS      = 2,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mdv_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [23:0] sample_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mdv_pkg::SAMPLE_W-1:0]      m_axis_tdata,   // [23:0] sample_out
  output logic                              m_axis_tlast,   // frame_end
  input  logic                              cfg_wr_en,
  input  logic [mdv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdv_pkg::CFG_W-1:0]         cfg_data
);

  localparam int WW     = $clog2(DELAY_LEN);
  localparam int TOTAL  = CHAN_SLOTS * DELAY_LEN;
  localparam int AW     = $clog2(TOTAL);
  localparam int CW     = (CHAN_SLOTS > 1) ? $clog2(CHAN_SLOTS) : 1;
  localparam int LINE   = DELAY_LEN * 256;
  localparam int FDW    = WW + 8;
  localparam int FOUR_S = 4 * SINE_TABLE_SIZE;
  localparam int IW     = $clog2(FOUR_S);
  localparam int SW     = $clog2(SINE_TABLE_SIZE + 1);
  localparam int OFF    = LINE * ((131072 + LINE - 1) / LINE);
  localparam int STEPS  = 24 - $clog2(LINE);
  localparam int KW     = $clog2(STEPS);

  typedef logic [14:0] sine_rom_t [SINE_TABLE_SIZE+1];

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] s;
    for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
      u  = (64'(k) << 28) / SINE_TABLE_SIZE;
      u2 = (u * u) >> 28;
      p  = mdv_pkg::SIN_C9;
      p  = mdv_pkg::SIN_C7 - ((u2 * p) >> 28);
      p  = mdv_pkg::SIN_C5 - ((u2 * p) >> 28);
      p  = mdv_pkg::SIN_C3 - ((u2 * p) >> 28);
      p  = mdv_pkg::SIN_C1 - ((u2 * p) >> 28);
      s  = (((u * p) >> 28) + 64'd4096) >> 13;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      rom[k] = 15'(s);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PHASE, S_SINE, S_DEPTH, S_DSUM, S_MOD,
    S_RDA, S_RDB, S_IMUL, S_IADD, S_MMUL, S_OUT
  } state_t;

  // configuration registers
  logic [22:0] phase_increment;
  logic [17:0] base_delay_q8;
  logic [17:0] depth_q8;
  logic [16:0] mix_q16;
  logic [1:0]  channels_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= mdv_pkg::PHASE_INC_RST;
      base_delay_q8   <= mdv_pkg::BASE_DELAY_RST;
      depth_q8        <= mdv_pkg::DEPTH_RST;
      mix_q16         <= mdv_pkg::MIX_RST;
      channels_in_use <= mdv_pkg::CHANNELS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mdv_pkg::REG_PHASE_INC:  phase_increment <= cfg_data;
        mdv_pkg::REG_BASE_DELAY: base_delay_q8   <= cfg_data[17:0];
        mdv_pkg::REG_DEPTH:      depth_q8        <= cfg_data[17:0];
        mdv_pkg::REG_MIX:        mix_q16         <= cfg_data[16:0];
        mdv_pkg::REG_CHANNELS:   channels_in_use <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  state_t state;

  // block state
  logic [AW-1:0]  clr_addr;
  logic [WW-1:0]  write_index;
  logic [31:0]    lfo_phase;
  logic [CW-1:0]  channel_count;
  logic [FDW-1:0] frame_delay;

  // per item working registers
  logic signed [23:0] x_q;
  logic [CW-1:0]      ch_q;
  logic [AW-1:0]      base_q;
  logic [3:0]         chans_q;
  logic [16:0]        mix_q;
  logic [IW-1:0]      idx_q;
  logic [14:0]        rom_q;
  logic               neg_q;
  logic signed [34:0] dprod_q;
  logic [22:0]        rem;
  logic [KW-1:0]      k;
  logic [7:0]         t_q;
  logic [AW-1:0]      b_addr_q;
  logic signed [23:0] a_q;
  logic signed [33:0] iprod_q;
  logic signed [23:0] delayed_q;
  logic signed [42:0] mprod_q;

  // delay memory
  logic signed [23:0] mem [TOTAL];
  logic signed [23:0] mem_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [23:0] mem_wdata;
  logic [AW-1:0]      rd_addr;

  // combinational helpers
  logic [46:0]        idx_prod;
  logic [1:0]         quad;
  logic [IW-1:0]      pos;
  logic [SW-1:0]      rom_addr;
  logic signed [15:0] sin_s;
  logic signed [18:0] dterm;
  logic signed [23:0] dsum;
  logic [31:0]        line_sh;
  logic               rem_ge;
  logic [22:0]        rem_red;
  logic [FDW:0]       rdiff;
  logic [FDW-1:0]     rpos;
  logic [WW-1:0]      rd_idx;
  logic [WW-1:0]      rd_idx_next;
  logic signed [24:0] diffab;
  logic signed [24:0] delta;
  logic signed [25:0] ysum;
  logic signed [23:0] ysat;
  logic               last;
  logic               out_free;
  logic [3:0]         chans_eff;
  logic [16:0]        mix_eff;

  always_comb begin
    idx_prod = 47'(lfo_phase) * 47'(FOUR_S);

    // quarter of the cycle and position inside it
    if (32'(idx_q) < 32'(SINE_TABLE_SIZE)) begin
      quad = 2'd0;
      pos  = idx_q;
    end else if (32'(idx_q) < 32'(2 * SINE_TABLE_SIZE)) begin
      quad = 2'd1;
      pos  = idx_q - IW'(SINE_TABLE_SIZE);
    end else if (32'(idx_q) < 32'(3 * SINE_TABLE_SIZE)) begin
      quad = 2'd2;
      pos  = idx_q - IW'(2 * SINE_TABLE_SIZE);
    end else begin
      quad = 2'd3;
      pos  = idx_q - IW'(3 * SINE_TABLE_SIZE);
    end
    rom_addr = quad[0] ? SW'(SINE_TABLE_SIZE - 32'(pos)) : SW'(pos);

    sin_s = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
    dterm = 19'(dprod_q >>> 16);
    dsum  = $signed({6'b0, base_delay_q8}) + 24'(dterm) + 24'(OFF);

    // one shift-subtract step of the modulo reduction
    line_sh = 32'(LINE) << k;
    rem_ge  = 32'(rem) >= line_sh;
    rem_red = rem_ge ? rem - 23'(line_sh) : rem;

    // read position behind the write index, wrapped into the line
    rdiff = {1'b0, write_index, 8'b0} - {1'b0, frame_delay};
    rpos  = rdiff[FDW] ? FDW'(rdiff + (FDW+1)'(LINE)) : rdiff[FDW-1:0];
    rd_idx = rpos[FDW-1:8];
    rd_idx_next = (rd_idx == WW'(DELAY_LEN - 1)) ? '0 : rd_idx + 1'b1;

    rd_addr = (state == S_RDA) ? base_q + AW'(rd_idx) : b_addr_q;

    mem_we    = (state == S_CLEAR) || (state == S_IMUL);
    mem_waddr = (state == S_CLEAR) ? clr_addr : base_q + AW'(write_index);
    mem_wdata = (state == S_CLEAR) ? '0 : x_q;

    diffab = 25'(mem_q) - 25'(a_q);
    delta  = 25'(delayed_q) - 25'(x_q);

    ysum = 26'(x_q) + 26'(mprod_q >>> 16);
    if (ysum > mdv_pkg::SAT_MAX) begin
      ysat = 24'(mdv_pkg::SAT_MAX);
    end else if (ysum < mdv_pkg::SAT_MIN) begin
      ysat = 24'(mdv_pkg::SAT_MIN);
    end else begin
      ysat = 24'(ysum);
    end

    last     = (4'(ch_q) + 4'd1) >= chans_q;
    out_free = !m_axis_tvalid || m_axis_tready;

    if (channels_in_use == 2'd0) begin
      chans_eff = 4'd1;
    end else if (32'(channels_in_use) > 32'(CHAN_SLOTS)) begin
      chans_eff = 4'(CHAN_SLOTS);
    end else begin
      chans_eff = 4'(channels_in_use);
    end
    mix_eff = (mix_q16 > mdv_pkg::MIX_ONE) ? mdv_pkg::MIX_ONE : mix_q16;
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      write_index   <= '0;
      lfo_phase     <= '0;
      channel_count <= '0;
      frame_delay   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // the output state drives tvalid itself
      if (m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TOTAL - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            x_q     <= $signed(s_axis_tdata);
            ch_q    <= channel_count;
            base_q  <= AW'(32'(channel_count) * DELAY_LEN);
            chans_q <= chans_eff;
            mix_q   <= mix_eff;
            state   <= (channel_count == '0) ? S_PHASE : S_RDA;
          end
        end
        S_PHASE: begin
          idx_q <= IW'(idx_prod >> 32);
          state <= S_SINE;
        end
        S_SINE: begin
          rom_q <= SINE_ROM[rom_addr];
          neg_q <= quad[1];
          state <= S_DEPTH;
        end
        S_DEPTH: begin
          dprod_q <= $signed({1'b0, depth_q8}) * sin_s;
          state   <= S_DSUM;
        end
        S_DSUM: begin
          rem   <= dsum[22:0];
          k     <= KW'(STEPS - 1);
          state <= S_MOD;
        end
        S_MOD: begin
          rem <= rem_red;
          if (k == '0) begin
            frame_delay <= FDW'(rem_red);
            state       <= S_RDA;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_RDA: begin
          t_q      <= rpos[7:0];
          b_addr_q <= base_q + AW'(rd_idx_next);
          state    <= S_RDB;
        end
        S_RDB: begin
          a_q   <= mem_q;
          state <= S_IMUL;
        end
        S_IMUL: begin
          iprod_q <= diffab * $signed({1'b0, t_q});
          state   <= S_IADD;
        end
        S_IADD: begin
          delayed_q <= 24'(25'(a_q) + 25'(iprod_q >>> 8));
          state     <= S_MMUL;
        end
        S_MMUL: begin
          mprod_q <= $signed({1'b0, mix_q}) * delta;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= ysat;
            m_axis_tlast  <= last;
            if (last) begin
              channel_count <= '0;
              write_index   <= (write_index == WW'(DELAY_LEN - 1)) ? '0 : write_index + 1'b1;
              lfo_phase     <= lfo_phase + 32'(phase_increment);
            end else begin
              channel_count <= CW'(ch_q + 1'b1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the reduced frame delay always lands inside the line
  a_fd_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && k == '0) |=> (32'(frame_delay) < 32'(LINE)))
    else $error("frame delay outside line");

  // an accepted item blocks further input until its result is loaded
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while busy");

  // the interpolation taps stay inside the channel line
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDA) |-> (32'(rd_idx) < 32'(DELAY_LEN) && 32'(rd_idx_next) < 32'(DELAY_LEN)))
    else $error("read index out of range");

endmodule
